### rtl/bs9_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bs9_pkg
// Shared sizes, register codes and bus types of the 9-point box stencil unit.
// ----------------------------------------------------------------------------
package bs9_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 4096;
   localparam int MAX_STEPS   = 4;
   localparam int SAMPLE_BITS = 24;
   localparam int COEF_BITS   = 18;
   localparam int FRAC_BITS   = 16;

   // fixed register widths
   localparam int ROW_CFG_BITS = 3 * COEF_BITS;
   localparam int GW_BITS      = 11;
   localparam int GH_BITS      = 13;
   localparam int TS_BITS      = 3;
   localparam int CSR_IDX_BITS = 3;

   localparam int W_BITS    = $clog2(MAX_WIDTH + 1);
   localparam int H_BITS    = $clog2(MAX_HEIGHT + 1);
   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int ROW_BITS  = $clog2(MAX_HEIGHT);
   localparam int TOT_BITS  = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 3);
   localparam int FIFO_AW   = $clog2(MAX_WIDTH + 3);
   localparam int FIFO_DEPTH = 1 << FIFO_AW;
   localparam int STEP_BITS = $clog2(MAX_STEPS + 1);

   localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
   localparam int ROWSUM_BITS = PROD_BITS + 2;
   localparam int SUM_BITS    = PROD_BITS + 4;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_COEF_NORTH  = 3'd0,
      CSR_COEF_MIDDLE = 3'd1,
      CSR_COEF_SOUTH  = 3'd2,
      CSR_GRID_WIDTH  = 3'd3,
      CSR_GRID_HEIGHT = 3'd4,
      CSR_TIME_STEPS  = 3'd5
   } csr_idx_type;

   // one step of the stage chain
   typedef struct packed {
      logic                   tv;    // slot carries a step
      logic                   have;  // step carries a sample
      logic                   last;  // sample is the final cell of a frame
      logic [SAMPLE_BITS-1:0] val;
   } token_type;

   // clamped geometry and weights shared by all stages
   typedef struct packed {
      logic [W_BITS-1:0]                       w;
      logic [H_BITS-1:0]                       h;
      logic [TOT_BITS-1:0]                     total;
      logic [2:0][ROW_CFG_BITS-1:0]            coef;   // [0] north .. [2] south
   } geom_type;

endpackage

### rtl/bs9_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bs9_stage
// One time step: sample queue, line memory, 3x3 window and weighted sum.
// ----------------------------------------------------------------------------
module bs9_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               clear,
   input  logic               active,
   input  bs9_pkg::geom_type  geom,
   input  bs9_pkg::token_type tok_i,
   output bs9_pkg::token_type tok_o
);
   import bs9_pkg::*;

   typedef struct packed {
      logic tv;
      logic have;
      logic last;
      logic intr;
   } ctrl_type;

   localparam logic signed [SUM_BITS-1:0] ROUND  = SUM_BITS'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [SUM_BITS-1:0] SAT_HI = SUM_BITS'((2 ** (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [SUM_BITS-1:0] SAT_LO = -SAT_HI - SUM_BITS'(1);

   // position counters
   logic [TOT_BITS-1:0] recv_ff, recv_in, sent_ff, sent_in;
   logic [COL_BITS-1:0] ck_ff, ck_in, wcol_ff, wcol_in;
   logic [ROW_BITS-1:0] rk_ff, rk_in;
   logic [FIFO_AW-1:0]  wptr_ff, wptr_in, rptr_ff, rptr_in;

   logic                arrive, emit, boundary, col_last, frame_done;
   logic [TOT_BITS-1:0] recv_inc, need_raw, need;
   logic [W_BITS-1:0]   w_m1;
   logic [H_BITS-1:0]   h_m1;
   logic [FIFO_AW-1:0]  fifo_fill;

   // memories
   logic [SAMPLE_BITS-1:0]   fifo_mem [FIFO_DEPTH];
   logic [2*SAMPLE_BITS-1:0] line_mem [MAX_WIDTH];
   logic [SAMPLE_BITS-1:0]   head_rd_ff;
   logic [2*SAMPLE_BITS-1:0] line_rd_ff;

   // pipeline
   ctrl_type               p1_ff, p1_in, p2_ff, p3_ff, p4_ff;
   logic                   p1_arr_ff, p1_byp_ff;
   logic [SAMPLE_BITS-1:0] p1_sample_ff;
   logic [COL_BITS-1:0]    p1_col_ff;
   logic [SAMPLE_BITS-1:0] p2_val_ff, p3_val_ff, p4_val_ff;

   logic signed [SAMPLE_BITS-1:0] win_ff  [3][3];
   logic signed [COEF_BITS-1:0]   wt      [3][3];
   logic signed [PROD_BITS-1:0]   prod_ff [3][3];
   logic signed [ROWSUM_BITS-1:0] rows_ff [3];
   logic signed [SUM_BITS-1:0]    sum, q;
   logic [SAMPLE_BITS-1:0]        sat_val;
   token_type                     tok_o_ff;

   // step bookkeeping
   always_comb begin
      arrive     = tok_i.tv && tok_i.have && active;
      recv_inc   = recv_ff + TOT_BITS'(arrive);
      need_raw   = sent_ff + TOT_BITS'(geom.w) + TOT_BITS'(2);
      need       = (need_raw > geom.total) ? geom.total : need_raw;
      emit       = tok_i.tv && active && (recv_inc >= need);
      w_m1       = geom.w - W_BITS'(1);
      h_m1       = geom.h - H_BITS'(1);
      col_last   = W_BITS'(ck_ff) == w_m1;
      boundary   = (rk_ff == '0) || (H_BITS'(rk_ff) == h_m1) || (ck_ff == '0) || col_last;
      frame_done = (sent_ff + TOT_BITS'(1)) == geom.total;
      fifo_fill  = wptr_ff - rptr_ff;

      recv_in = recv_ff;
      sent_in = sent_ff;
      ck_in   = ck_ff;
      rk_in   = rk_ff;
      wcol_in = wcol_ff;
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      if (arrive) begin
         wptr_in = wptr_ff + FIFO_AW'(1);
         wcol_in = (W_BITS'(wcol_ff) == w_m1) ? '0 : wcol_ff + COL_BITS'(1);
      end
      recv_in = recv_inc;
      if (emit) begin
         rptr_in = rptr_ff + FIFO_AW'(1);
         if (frame_done) begin
            // rebase onto the next frame
            sent_in = '0;
            ck_in   = '0;
            rk_in   = '0;
            recv_in = recv_inc - geom.total;
         end else begin
            sent_in = sent_ff + TOT_BITS'(1);
            if (col_last) begin
               ck_in = '0;
               rk_in = rk_ff + ROW_BITS'(1);
            end else begin
               ck_in = ck_ff + COL_BITS'(1);
            end
         end
      end

      p1_in.tv   = tok_i.tv;
      p1_in.have = active ? emit : tok_i.have;
      p1_in.last = active ? (emit && frame_done) : tok_i.last;
      p1_in.intr = emit && !boundary;
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         recv_ff <= '0;
         sent_ff <= '0;
         ck_ff   <= '0;
         rk_ff   <= '0;
         wcol_ff <= '0;
         wptr_ff <= '0;
         rptr_ff <= '0;
      end else if (en) begin
         recv_ff <= recv_in;
         sent_ff <= sent_in;
         ck_ff   <= ck_in;
         rk_ff   <= rk_in;
         wcol_ff <= wcol_in;
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
      end
   end

   // queue of pending centers, and line memory holding the two rows above
   always_ff @(posedge clock) begin
      if (en) begin
         if (arrive) begin
            fifo_mem[wptr_ff] <= tok_i.val;
         end
         head_rd_ff <= fifo_mem[rptr_ff];
         line_rd_ff <= line_mem[wcol_ff];
         if (p1_arr_ff) begin
            line_mem[p1_col_ff] <= {line_rd_ff[SAMPLE_BITS-1:0], p1_sample_ff};
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            wt[r][c] = geom.coef[r][COEF_BITS*c +: COEF_BITS];
         end
      end
   end

   always_comb begin
      sum = SUM_BITS'(rows_ff[0]) + SUM_BITS'(rows_ff[1]) + SUM_BITS'(rows_ff[2]) + ROUND;
      q   = sum >>> FRAC_BITS;
      if (q > SAT_HI) begin
         sat_val = SAT_HI[SAMPLE_BITS-1:0];
      end else if (q < SAT_LO) begin
         sat_val = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
         sat_val = q[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff       <= '0;
         p2_ff       <= '0;
         p3_ff       <= '0;
         p4_ff       <= '0;
         p1_arr_ff   <= 1'b0;
         tok_o_ff.tv <= 1'b0;
      end else if (en) begin
         p1_ff       <= p1_in;
         p1_arr_ff   <= arrive;
         p2_ff       <= p1_ff;
         p3_ff       <= p2_ff;
         p4_ff       <= p3_ff;
         tok_o_ff.tv <= p4_ff.tv;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_byp_ff    <= !active;
         p1_sample_ff <= tok_i.val;
         p1_col_ff    <= wcol_ff;
         p2_val_ff    <= p1_byp_ff ? p1_sample_ff : head_rd_ff;
         if (p1_arr_ff) begin
            // shift in the column whose south cell just arrived
            for (int r = 0; r < 3; r++) begin
               win_ff[r][0] <= win_ff[r][1];
               win_ff[r][1] <= win_ff[r][2];
            end
            win_ff[0][2] <= line_rd_ff[2*SAMPLE_BITS-1:SAMPLE_BITS];
            win_ff[1][2] <= line_rd_ff[SAMPLE_BITS-1:0];
            win_ff[2][2] <= p1_sample_ff;
         end
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[r][c] <= PROD_BITS'(win_ff[r][c] * wt[r][c]);
            end
            rows_ff[r] <= ROWSUM_BITS'(prod_ff[r][0]) + ROWSUM_BITS'(prod_ff[r][1])
                        + ROWSUM_BITS'(prod_ff[r][2]);
         end
         p3_val_ff     <= p2_val_ff;
         p4_val_ff     <= p3_val_ff;
         tok_o_ff.have <= p4_ff.have;
         tok_o_ff.last <= p4_ff.last;
         tok_o_ff.val  <= p4_ff.intr ? sat_val : p4_val_ff;
      end
   end

   assign tok_o = tok_o_ff;

   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_fill <= FIFO_AW'(geom.w) + FIFO_AW'(2))
      else $error("center queue holds more than a row and two cells");

   a_interior_on_arrival: assert property (@(posedge clock) disable iff (reset)
      emit && !boundary |-> arrive)
      else $error("interior cell emitted without its southeast neighbor");

   a_sent_in_frame: assert property (@(posedge clock) disable iff (reset)
      sent_ff < geom.total)
      else $error("emit counter ran past the frame");

endmodule

### rtl/box_stencil_9pt_time_tiled_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_stencil_9pt_time_tiled_unit
// Chain of 3x3 weighted box stencil stages over a raster-order grid stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one grid sample per item in raster order; req_tuser set
//   marks a filler item that carries no sample and only pushes the stages.
//   Each active stage lags its input by grid_width+1 items, so after a frame
//   send time_steps*(grid_width+1) fillers (or the next frame) to drain it.
//   rsp_* returns the final grid in raster order; rsp_tlast marks the final
//   cell of a frame. Items that produce no cell give no rsp item.
//   csr_* writes one register per handshake; csr_ready is always high. Write
//   only while idle. A geometry write (width, height, steps) restarts all
//   stages at the top of a frame.
// Timing:
//   One item per cycle sustained. Every stage is a registered pipeline
//   (queue and line memory read, window shift, multiply, row sums,
//   round/saturate), and an output register follows the last stage.
//   When a result waits in the output register and rsp_tready is low, the
//   whole chain holds and req_tready drops until the result is taken.
// Reset: clears counters and pipeline valids; registers return to defaults.
// ----------------------------------------------------------------------------
module box_stencil_9pt_time_tiled_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // slave side
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [bs9_pkg::SAMPLE_BITS-1:0]      req_tdata,   // [23:0] sample_in
   input  logic                                 req_tuser,   // [0] filler
   // master side
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [bs9_pkg::SAMPLE_BITS-1:0]      rsp_tdata,   // [23:0] sample_out
   output logic                                 rsp_tlast,
   // register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bs9_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [bs9_pkg::ROW_CFG_BITS-1:0]     csr_data
);
   import bs9_pkg::*;

   logic [ROW_CFG_BITS-1:0] coef_n_ff, coef_m_ff, coef_s_ff;
   logic [GW_BITS-1:0]      grid_w_ff;
   logic [GH_BITS-1:0]      grid_h_ff;
   logic [TS_BITS-1:0]      steps_ff;

   logic                    csr_fire, geom_clear, en;
   logic [STEP_BITS-1:0]    steps_eff;
   geom_type                geom;
   token_type               tok [MAX_STEPS+1];

   logic                    out_valid_ff;
   logic [SAMPLE_BITS-1:0]  out_data_ff;
   logic                    out_last_ff;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   always_comb begin
      geom_clear = 1'b0;
      case (csr_idx_type'(csr_index))
         CSR_GRID_WIDTH, CSR_GRID_HEIGHT, CSR_TIME_STEPS: geom_clear = csr_fire;
         default: geom_clear = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_n_ff <= '0;
         coef_m_ff <= '0;
         coef_s_ff <= '0;
         grid_w_ff <= GW_BITS'(1024);
         grid_h_ff <= GH_BITS'(1024);
         steps_ff  <= TS_BITS'(1);
      end else if (csr_fire) begin
         case (csr_idx_type'(csr_index))
            CSR_COEF_NORTH:  coef_n_ff <= csr_data;
            CSR_COEF_MIDDLE: coef_m_ff <= csr_data;
            CSR_COEF_SOUTH:  coef_s_ff <= csr_data;
            CSR_GRID_WIDTH:  grid_w_ff <= csr_data[GW_BITS-1:0];
            CSR_GRID_HEIGHT: grid_h_ff <= csr_data[GH_BITS-1:0];
            CSR_TIME_STEPS:  steps_ff  <= csr_data[TS_BITS-1:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // clamp geometry into the supported range
   always_comb begin
      if (grid_w_ff < GW_BITS'(3)) begin
         geom.w = W_BITS'(3);
      end else if (grid_w_ff > GW_BITS'(MAX_WIDTH)) begin
         geom.w = W_BITS'(MAX_WIDTH);
      end else begin
         geom.w = W_BITS'(grid_w_ff);
      end
      if (grid_h_ff < GH_BITS'(3)) begin
         geom.h = H_BITS'(3);
      end else if (grid_h_ff > GH_BITS'(MAX_HEIGHT)) begin
         geom.h = H_BITS'(MAX_HEIGHT);
      end else begin
         geom.h = H_BITS'(grid_h_ff);
      end
      if (steps_ff == '0) begin
         steps_eff = STEP_BITS'(1);
      end else if (steps_ff > TS_BITS'(MAX_STEPS)) begin
         steps_eff = STEP_BITS'(MAX_STEPS);
      end else begin
         steps_eff = STEP_BITS'(steps_ff);
      end
      geom.total   = TOT_BITS'(geom.w) * TOT_BITS'(geom.h);
      geom.coef[0] = coef_n_ff;
      geom.coef[1] = coef_m_ff;
      geom.coef[2] = coef_s_ff;
   end

   // advance the chain unless a finished result is still waiting
   assign en         = !out_valid_ff || rsp_tready;
   assign req_tready = en;

   always_comb begin
      tok[0].tv   = req_tvalid;
      tok[0].have = !req_tuser;
      tok[0].last = 1'b0;
      tok[0].val  = req_tdata;
   end

   for (genvar s = 0; s < MAX_STEPS; s++) begin : g_stage
      bs9_stage u_stage (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .clear  (geom_clear),
         .active (STEP_BITS'(s) < steps_eff),
         .geom   (geom),
         .tok_i  (tok[s]),
         .tok_o  (tok[s+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= tok[MAX_STEPS].tv && tok[MAX_STEPS].have;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_data_ff <= tok[MAX_STEPS].val;
         out_last_ff <= tok[MAX_STEPS].last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
